@@ design/pgr_pkg.sv @@
// ----------------------------------------------------------------------------
// pgr_pkg
// Shared types, constants and the font table of the glyph renderer.
// ----------------------------------------------------------------------------
package pgr_pkg;

	// Font geometry
	localparam int GLYPH_WIDTH  = 6;
	localparam int GLYPH_HEIGHT = 8;
	localparam int FIRST_CODE   = 32;
	localparam int NUM_GLYPHS   = 95;

	// Field widths
	localparam int CODE_W   = 8;
	localparam int PIX_W    = 8;
	localparam int CURSOR_W = 16;
	localparam int OFFSET_W = 17;
	localparam int INSET_W  = 2;
	localparam int COL_W    = $clog2(GLYPH_WIDTH + 1);
	localparam int ROW_W    = $clog2(GLYPH_HEIGHT);
	localparam int IDX_W    = $clog2(NUM_GLYPHS);
	localparam int ENTRY_W  = 2 * INSET_W + GLYPH_WIDTH * PIX_W;

	// Command queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Register file
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_ROW_STRIDE   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FG_VALUE     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BG_VALUE     = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_COLUMN_LIMIT = 2'd3;

	typedef logic [GLYPH_WIDTH-1:0][PIX_W-1:0] glyph_cols_t;

	// One character to draw, handed from front to back
	typedef struct packed {
		logic [CURSOR_W-1:0] cursor;
		logic [COL_W-1:0]    ncols;
		glyph_cols_t         cols;   // cols[c] is drawn column c
	} cmd_t;

	// Font entry: {lead, trail, col0 .. col5}, col0 in the top byte
	localparam logic [ENTRY_W-1:0] GLYPH_ROM [NUM_GLYPHS] = '{
		52'h9000000000000, 52'hE0000005E0000, 52'h9000006000600, 52'h400247E247E24,
		52'h4004854FE5424, 52'h5004820104800, 52'h400344A542050, 52'hE000000060000,
		52'hA00003C420000, 52'hA0000423C0000, 52'h9000054385400, 52'h9000010381000,
		52'hA000080600000, 52'hA000010100000, 52'hE000000400000, 52'h6006018060000,
		52'h900003C423C00, 52'h90000047E0000, 52'h9000062524C00, 52'h90000424A3600,
		52'h900001C107E00, 52'h900004E4A3200, 52'h900003C4A3200, 52'h9000002720E00,
		52'h90000344A3400, 52'h900004C523C00, 52'hE000000480000, 52'hA000080640000,
		52'h9000010284400, 52'h9000028282800, 52'h9000044281000, 52'h90000520A0400,
		52'h4007C8292AA3C, 52'h900007C127C00, 52'h900007E4A3400, 52'h900003C424200,
		52'h900007E423C00, 52'h900007E4A4200, 52'h900007E0A0200, 52'h900003C427200,
		52'h900007E087E00, 52'h90000427E4200, 52'hA0000807E0000, 52'h900007E087600,
		52'h900007E404000, 52'h4007E0408047E, 52'h5007E04087E00, 52'h900003C423C00,
		52'h900007E120C00, 52'h900003CC2BC00, 52'h900007E126C00, 52'h90000444A3200,
		52'h90000027E0200, 52'h900003E407E00, 52'h900007E201E00, 52'h4003E4030403E,
		52'h9000066186600, 52'h900000E700E00, 52'h90000625A4600, 52'hA00007E420000,
		52'h9000006186000, 52'hA0000427E0000, 52'h40008047E0408, 52'h9000080808000,
		52'h500487C4A4200, 52'h9000020547800, 52'h900007E443800, 52'hA000038440000,
		52'h9000038447E00, 52'h9000038544C00, 52'hA00007C0A0000, 52'h9000098A47C00,
		52'h900007E047800, 52'hE0000007A0000, 52'hA0000807A0000, 52'h900007E186400,
		52'hE0000007E0000, 52'h4007C047C0478, 52'h900007C047800, 52'h9000038443800,
		52'h90000FC447800, 52'h900003824FC00, 52'hA000078040000, 52'h9000048542400,
		52'hA00003E440000, 52'h900003C407C00, 52'h900007C201C00, 52'h4003C4038403C,
		52'h900006C106C00, 52'h900001CA07C00, 52'h9000064544C00, 52'h9000008764200,
		52'hE0000007E0000, 52'h6004276080000, 52'h5000402040200
	};

endpackage

@@ design/pgr_front.sv @@
// ----------------------------------------------------------------------------
// pgr_front
// Accepts characters, looks up the font, owns the cursor and queues commands.
// ----------------------------------------------------------------------------
module pgr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [pgr_pkg::CODE_W-1:0]    char_code,
	input  logic                          new_string,
	input  logic [pgr_pkg::CURSOR_W-1:0]  column_limit,
	input  logic                          cmd_full,
	output logic                          cmd_push,
	output pgr_pkg::cmd_t                 cmd
);

	logic [pgr_pkg::CURSOR_W-1:0] cursor_q;
	logic [pgr_pkg::CURSOR_W-1:0] cur_base;
	logic                         accept;
	logic                         in_range;
	logic                         draw;
	logic [pgr_pkg::IDX_W-1:0]    rom_idx;
	logic [pgr_pkg::ENTRY_W-1:0]  entry;
	logic [pgr_pkg::INSET_W-1:0]  lead;
	logic [pgr_pkg::INSET_W-1:0]  trail;
	logic [pgr_pkg::COL_W-1:0]    ncols;
	logic [pgr_pkg::PIX_W-1:0]    rom_cols [pgr_pkg::GLYPH_WIDTH];
	pgr_pkg::glyph_cols_t         cols;
	logic [pgr_pkg::CURSOR_W:0]   next_cursor;

	assign accept   = push && !cmd_full;
	assign cur_base = new_string ? '0 : cursor_q;

	// Classify the code and read its font entry
	always_comb begin
		in_range = (char_code >= pgr_pkg::CODE_W'(pgr_pkg::FIRST_CODE)) &&
			(char_code < pgr_pkg::CODE_W'(pgr_pkg::FIRST_CODE + pgr_pkg::NUM_GLYPHS));
		rom_idx  = in_range ?
			pgr_pkg::IDX_W'(char_code - pgr_pkg::CODE_W'(pgr_pkg::FIRST_CODE)) : '0;
		entry    = pgr_pkg::GLYPH_ROM[rom_idx];
		lead     = entry[pgr_pkg::ENTRY_W-1 -: pgr_pkg::INSET_W];
		trail    = entry[pgr_pkg::ENTRY_W-1-pgr_pkg::INSET_W -: pgr_pkg::INSET_W];
		ncols    = pgr_pkg::COL_W'(pgr_pkg::GLYPH_WIDTH) - pgr_pkg::COL_W'(lead)
			- pgr_pkg::COL_W'(trail);
		draw     = in_range && (cur_base < column_limit) && (ncols != '0);
	end

	// Rotate stored columns so drawn column 0 comes first
	always_comb begin
		logic [pgr_pkg::COL_W:0] k;
		for (int i = 0; i < pgr_pkg::GLYPH_WIDTH; i++) begin
			rom_cols[i] = entry[(pgr_pkg::GLYPH_WIDTH - i) * pgr_pkg::PIX_W - 1 -: pgr_pkg::PIX_W];
		end
		for (int c = 0; c < pgr_pkg::GLYPH_WIDTH; c++) begin
			k = (pgr_pkg::COL_W + 1)'(c) + (pgr_pkg::COL_W + 1)'(lead);
			if (k >= (pgr_pkg::COL_W + 1)'(pgr_pkg::GLYPH_WIDTH)) begin
				k = k - (pgr_pkg::COL_W + 1)'(pgr_pkg::GLYPH_WIDTH);
			end
			cols[c] = rom_cols[k[pgr_pkg::COL_W-1:0]];
		end
	end

	// Saturating cursor advance: drawn columns plus one spacing column
	assign next_cursor = {1'b0, cur_base} + (pgr_pkg::CURSOR_W + 1)'(ncols)
		+ (pgr_pkg::CURSOR_W + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (accept) begin
			if (draw) begin
				cursor_q <= next_cursor[pgr_pkg::CURSOR_W] ? '1 :
					next_cursor[pgr_pkg::CURSOR_W-1:0];
			end else begin
				cursor_q <= cur_base;
			end
		end
	end

	assign cmd_push   = accept && draw;
	assign cmd.cursor = cur_base;
	assign cmd.ncols  = ncols;
	assign cmd.cols   = cols;

endmodule

@@ design/pgr_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// pgr_cmd_fifo
// Short command queue that decouples the front from the pixel back end.
// ----------------------------------------------------------------------------
module pgr_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  pgr_pkg::cmd_t wr_data,
	input  logic          rd_en,
	output pgr_pkg::cmd_t rd_data,
	output logic          full,
	output logic          empty
);

	pgr_pkg::cmd_t                  entries_q [pgr_pkg::FIFO_DEPTH];
	logic [pgr_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [pgr_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [pgr_pkg::FIFO_CNT_W-1:0] count_q;
	logic                           do_wr;
	logic                           do_rd;

	assign full  = (count_q == pgr_pkg::FIFO_CNT_W'(pgr_pkg::FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = entries_q[rd_ptr_q];

	// Store payload
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + pgr_pkg::FIFO_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + pgr_pkg::FIFO_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + pgr_pkg::FIFO_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - pgr_pkg::FIFO_CNT_W'(1);
			end
		end
	end

endmodule

@@ design/pgr_back.sv @@
// ----------------------------------------------------------------------------
// pgr_back
// Walks one queued character column by column, top to bottom, one pixel
// per cycle while the receiver keeps popping, into an output register.
// ----------------------------------------------------------------------------
module pgr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pgr_pkg::cmd_t                 cmd,
	input  logic                          cmd_empty,
	output logic                          cmd_pop,
	input  logic [pgr_pkg::PIX_W-1:0]     row_stride,
	input  logic [pgr_pkg::PIX_W-1:0]     fg_value,
	input  logic [pgr_pkg::PIX_W-1:0]     bg_value,
	input  logic                          pop,
	output logic                          empty,
	output logic [pgr_pkg::OFFSET_W-1:0]  pixel_offset,
	output logic [pgr_pkg::PIX_W-1:0]     pixel_value,
	output logic                          last_pixel
);

	logic                          busy_q;
	pgr_pkg::cmd_t                 cmd_q;
	logic [pgr_pkg::COL_W-1:0]     col_q;
	logic [pgr_pkg::ROW_W-1:0]     row_q;
	logic [pgr_pkg::OFFSET_W-1:0]  col_base_q;
	logic [pgr_pkg::OFFSET_W-1:0]  acc_q;
	logic                          out_valid_q;
	logic [pgr_pkg::OFFSET_W-1:0]  offset_q;
	logic [pgr_pkg::PIX_W-1:0]     value_q;
	logic                          last_q;
	logic                          out_take;
	logic                          adv;
	logic                          row_end;
	logic                          char_end;
	logic                          bit_set;

	assign out_take = pop && out_valid_q;
	assign adv      = busy_q && (!out_valid_q || out_take);
	assign cmd_pop  = !busy_q && !cmd_empty;
	assign row_end  = (row_q == pgr_pkg::ROW_W'(pgr_pkg::GLYPH_HEIGHT - 1));
	assign char_end = row_end && (col_q == cmd_q.ncols - pgr_pkg::COL_W'(1));
	assign bit_set  = cmd_q.cols[col_q][row_q];

	// Hold the current command
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	// Step row and column, keep the running buffer offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			col_base_q <= '0;
			acc_q      <= '0;
		end else if (cmd_pop) begin
			busy_q     <= 1'b1;
			col_q      <= '0;
			row_q      <= '0;
			col_base_q <= pgr_pkg::OFFSET_W'(cmd.cursor);
			acc_q      <= pgr_pkg::OFFSET_W'(cmd.cursor);
		end else if (adv) begin
			if (char_end) begin
				busy_q <= 1'b0;
			end else if (row_end) begin
				col_q      <= col_q + pgr_pkg::COL_W'(1);
				row_q      <= '0;
				col_base_q <= col_base_q + pgr_pkg::OFFSET_W'(1);
				acc_q      <= col_base_q + pgr_pkg::OFFSET_W'(1);
			end else begin
				row_q <= row_q + pgr_pkg::ROW_W'(1);
				acc_q <= acc_q + pgr_pkg::OFFSET_W'(row_stride);
			end
		end
	end

	// Output register: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			offset_q <= acc_q;
			value_q  <= bit_set ? fg_value : bg_value;
			last_q   <= char_end;
		end
	end

	assign empty        = !out_valid_q;
	assign pixel_offset = offset_q;
	assign pixel_value  = value_q;
	assign last_pixel   = last_q;

endmodule

@@ design/proportional_glyph_renderer_core.sv @@
// ----------------------------------------------------------------------------
// proportional_glyph_renderer_core
// Renders characters of a 6x8 proportional font as a stream of pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (push/full): one character per item, char_code plus
//   new_string, which restarts the cursor at column zero first.
//   Result queue (empty/pop): one item per pixel, pixel_offset, pixel_value
//   and last_pixel, which marks the final pixel of a character. Each drawn
//   column comes out top to bottom, columns left to right.
//   Codes outside 0x20..0x7e, and characters whose cursor is at or beyond
//   column_limit, produce no items.
//   Throughput: 8 items per drawn column, one per cycle while pop keeps up,
//   plus a load step for each character; set by the single-pixel back end.
//   A two-entry command queue lets up to two more characters be taken while
//   one is drawn.
//   Path: a taken character goes through the command queue and the back
//   end's command register, then its first pixel enters the output register.
//   Receiver stall: the pending pixel holds while pop is low; the back end
//   stops, then the queue fills and full rises.
//   Reset clears the cursor, the queue and the output register and loads
//   the register defaults (stride 128, fg 255, bg 0, limit 128).
//   Registers are to be written over the APB port only while idle; unenforced.
// ----------------------------------------------------------------------------
module proportional_glyph_renderer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pgr_pkg::ADDR_W-1:0]    paddr,
	input  logic [pgr_pkg::DATA_W-1:0]    pwdata,
	output logic [pgr_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	// characters
	input  logic                          push,
	output logic                          full,
	input  logic [pgr_pkg::CODE_W-1:0]    char_code,
	input  logic                          new_string,
	// pixels
	output logic                          empty,
	input  logic                          pop,
	output logic [pgr_pkg::OFFSET_W-1:0]  pixel_offset,
	output logic [pgr_pkg::PIX_W-1:0]     pixel_value,
	output logic                          last_pixel
);

	logic [pgr_pkg::PIX_W-1:0]    row_stride_q;
	logic [pgr_pkg::PIX_W-1:0]    fg_value_q;
	logic [pgr_pkg::PIX_W-1:0]    bg_value_q;
	logic [pgr_pkg::CURSOR_W-1:0] column_limit_q;
	logic [pgr_pkg::REG_IDX_W-1:0] reg_idx;
	logic                         reg_wr;
	logic                         cmd_push;
	logic                         cmd_pop;
	logic                         cmd_full;
	logic                         cmd_empty;
	pgr_pkg::cmd_t                cmd_in;
	pgr_pkg::cmd_t                cmd_out;

	assign pready  = 1'b1;
	assign reg_idx = paddr[pgr_pkg::ADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_stride_q   <= pgr_pkg::PIX_W'(128);
			fg_value_q     <= pgr_pkg::PIX_W'(255);
			bg_value_q     <= '0;
			column_limit_q <= pgr_pkg::CURSOR_W'(128);
		end else if (reg_wr) begin
			case (reg_idx)
				pgr_pkg::REG_ROW_STRIDE:   row_stride_q   <= pwdata[pgr_pkg::PIX_W-1:0];
				pgr_pkg::REG_FG_VALUE:     fg_value_q     <= pwdata[pgr_pkg::PIX_W-1:0];
				pgr_pkg::REG_BG_VALUE:     bg_value_q     <= pwdata[pgr_pkg::PIX_W-1:0];
				pgr_pkg::REG_COLUMN_LIMIT: column_limit_q <= pwdata[pgr_pkg::CURSOR_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (reg_idx)
			pgr_pkg::REG_ROW_STRIDE:   prdata = pgr_pkg::DATA_W'(row_stride_q);
			pgr_pkg::REG_FG_VALUE:     prdata = pgr_pkg::DATA_W'(fg_value_q);
			pgr_pkg::REG_BG_VALUE:     prdata = pgr_pkg::DATA_W'(bg_value_q);
			pgr_pkg::REG_COLUMN_LIMIT: prdata = pgr_pkg::DATA_W'(column_limit_q);
			default:                   prdata = '0;
		endcase
	end

	assign full = cmd_full;

	pgr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.char_code    (char_code),
		.new_string   (new_string),
		.column_limit (column_limit_q),
		.cmd_full     (cmd_full),
		.cmd_push     (cmd_push),
		.cmd          (cmd_in)
	);

	pgr_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.full    (cmd_full),
		.empty   (cmd_empty)
	);

	pgr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd_out),
		.cmd_empty    (cmd_empty),
		.cmd_pop      (cmd_pop),
		.row_stride   (row_stride_q),
		.fg_value     (fg_value_q),
		.bg_value     (bg_value_q),
		.pop          (pop),
		.empty        (empty),
		.pixel_offset (pixel_offset),
		.pixel_value  (pixel_value),
		.last_pixel   (last_pixel)
	);

endmodule

@@ design/pgr_checker.sv @@
// ----------------------------------------------------------------------------
// pgr_checker
// Port-level checks of the result queue, bound to the renderer core.
// ----------------------------------------------------------------------------
module pgr_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          empty,
	input  logic                          pop,
	input  logic [pgr_pkg::OFFSET_W-1:0]  pixel_offset,
	input  logic                          last_pixel
);

	// A waiting pixel stays until taken
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("pixel dropped while stalled");

	// A stalled pixel keeps its offset
	a_hold_offset: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(pixel_offset))
		else $error("pixel offset changed while stalled");

	// Nothing waits right after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> empty)
		else $error("result present right after reset");

	// Inside a character the next pixel follows with no gap
	a_run_dense: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last_pixel |=> !empty)
		else $error("gap inside a character's pixel run");

endmodule

bind proportional_glyph_renderer_core pgr_checker u_pgr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.pixel_offset (pixel_offset),
	.last_pixel   (last_pixel)
);

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Regression bench for the proportional glyph renderer core.
// Characters go in over the push/full queue and registers over APB. A local
// font table and pen model predict every pixel write, and each popped pixel is
// compared field by field with the oldest prediction. Directed checks cover
// the font edges, dropped codes, register extremes and the column limit.
// Random strings then run under several register settings with random gaps
// on both queues.
// ----------------------------------------------------------------------------
module tb;

	localparam int SETTLE_CYCLES = 16;
	localparam int REPORT_CAP    = 50;
	localparam int PHASE_CHARS   = 36;

	localparam logic [pgr_pkg::CODE_W-1:0] CH_END   = 8'h00;
	localparam logic [pgr_pkg::CODE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [pgr_pkg::CODE_W-1:0] CH_HASH  = 8'h23;
	localparam logic [pgr_pkg::CODE_W-1:0] CH_TILDE = 8'h7e;
	localparam logic [pgr_pkg::CODE_W-1:0] CH_LAST  = 8'hff;

	// {lead, trail, col0 .. col5}, col0 in the top byte; row 0 is bit 0
	localparam logic [55:0] FONT_ROM [pgr_pkg::NUM_GLYPHS] = '{
		56'h21_000000000000, 56'h32_0000005e0000, 56'h21_000006000600, 56'h10_00247e247e24,
		56'h10_004854fe5424, 56'h11_004820104800, 56'h10_00344a542050, 56'h32_000000060000,
		56'h22_00003c420000, 56'h22_0000423c0000, 56'h21_000054385400, 56'h21_000010381000,
		56'h22_000080600000, 56'h22_000010100000, 56'h32_000000400000, 56'h12_006018060000,
		56'h21_00003c423c00, 56'h21_0000047e0000, 56'h21_000062524c00, 56'h21_0000424a3600,
		56'h21_00001c107e00, 56'h21_00004e4a3200, 56'h21_00003c4a3200, 56'h21_000002720e00,
		56'h21_0000344a3400, 56'h21_00004c523c00, 56'h32_000000480000, 56'h22_000080640000,
		56'h21_000010284400, 56'h21_000028282800, 56'h21_000044281000, 56'h21_0000520a0400,
		56'h10_007c8292aa3c, 56'h21_00007c127c00, 56'h21_00007e4a3400, 56'h21_00003c424200,
		56'h21_00007e423c00, 56'h21_00007e4a4200, 56'h21_00007e0a0200, 56'h21_00003c427200,
		56'h21_00007e087e00, 56'h21_0000427e4200, 56'h22_0000807e0000, 56'h21_00007e087600,
		56'h21_00007e404000, 56'h10_007e0408047e, 56'h11_007e04087e00, 56'h21_00003c423c00,
		56'h21_00007e120c00, 56'h21_00003cc2bc00, 56'h21_00007e126c00, 56'h21_0000444a3200,
		56'h21_0000027e0200, 56'h21_00003e407e00, 56'h21_00007e201e00, 56'h10_003e4030403e,
		56'h21_000066186600, 56'h21_00000e700e00, 56'h21_0000625a4600, 56'h22_00007e420000,
		56'h21_000006186000, 56'h22_0000427e0000, 56'h10_0008047e0408, 56'h21_000080808000,
		56'h11_00487c4a4200, 56'h21_000020547800, 56'h21_00007e443800, 56'h22_000038440000,
		56'h21_000038447e00, 56'h21_000038544c00, 56'h22_00007c0a0000, 56'h21_000098a47c00,
		56'h21_00007e047800, 56'h32_0000007a0000, 56'h22_0000807a0000, 56'h21_00007e186400,
		56'h32_0000007e0000, 56'h10_007c047c0478, 56'h21_00007c047800, 56'h21_000038443800,
		56'h21_0000fc447800, 56'h21_00003824fc00, 56'h22_000078040000, 56'h21_000048542400,
		56'h22_00003e440000, 56'h21_00003c407c00, 56'h21_00007c201c00, 56'h10_003c4038403c,
		56'h21_00006c106c00, 56'h21_00001ca07c00, 56'h21_000064544c00, 56'h21_000008764200,
		56'h32_0000007e0000, 56'h12_004276080000, 56'h11_000402040200
	};

	typedef struct packed {
		logic [pgr_pkg::OFFSET_W-1:0] offset;
		logic [pgr_pkg::PIX_W-1:0]    value;
		logic                         last;
	} pixel_t;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         psel       = 1'b0;
	logic                         penable    = 1'b0;
	logic                         pwrite     = 1'b0;
	logic [pgr_pkg::ADDR_W-1:0]   paddr      = '0;
	logic [pgr_pkg::DATA_W-1:0]   pwdata     = '0;
	logic [pgr_pkg::DATA_W-1:0]   prdata;
	logic                         pready;
	logic                         push       = 1'b0;
	logic                         full;
	logic [pgr_pkg::CODE_W-1:0]   char_code  = '0;
	logic                         new_string = 1'b0;
	logic                         empty;
	logic                         pop        = 1'b0;
	logic [pgr_pkg::OFFSET_W-1:0] pixel_offset;
	logic [pgr_pkg::PIX_W-1:0]    pixel_value;
	logic                         last_pixel;

	// Shadow of the register file and the pen position
	logic [7:0]                   stride_reg = 8'd128;
	logic [pgr_pkg::PIX_W-1:0]    fg_reg     = 8'd255;
	logic [pgr_pkg::PIX_W-1:0]    bg_reg     = 8'd0;
	logic [pgr_pkg::CURSOR_W-1:0] limit_reg  = 16'd128;
	logic [pgr_pkg::CURSOR_W-1:0] pen_col    = '0;

	pixel_t pending_pixels[$];
	int     sent_chars     = 0;
	int     mismatch_count = 0;
	int     stall_left     = 0;
	bit     idle_on        = 1'b1;

	proportional_glyph_renderer_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.push         (push),
		.full         (full),
		.char_code    (char_code),
		.new_string   (new_string),
		.empty        (empty),
		.pop          (pop),
		.pixel_offset (pixel_offset),
		.pixel_value  (pixel_value),
		.last_pixel   (last_pixel)
	);

	always #5 clk = ~clk;

	// Hard stop in case the pixel stream hangs
	initial begin
		#50_000_000;
		$display("proportional_glyph_renderer_core regression: fail");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		if (!idle_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Any printable code
	function automatic logic [pgr_pkg::CODE_W-1:0] rand_glyph();
		return pgr_pkg::CODE_W'($urandom_range(pgr_pkg::FIRST_CODE,
			pgr_pkg::FIRST_CODE + pgr_pkg::NUM_GLYPHS - 1));
	endfunction

	// Render one character into the list of pixel writes it must produce
	function automatic void render_glyph(input logic [pgr_pkg::CODE_W-1:0] code,
		input logic restart);
		logic [55:0] entry;
		logic [7:0]  bits;
		int          lead, trail, ncols, sum;
		pixel_t      pix;
		if (restart)
			pen_col = '0;
		if (code < pgr_pkg::FIRST_CODE || code >= pgr_pkg::FIRST_CODE + pgr_pkg::NUM_GLYPHS)
			return;
		if (pen_col >= limit_reg)
			return;
		entry = FONT_ROM[code - pgr_pkg::FIRST_CODE];
		lead  = int'(entry[55:52]);
		trail = int'(entry[51:48]);
		ncols = pgr_pkg::GLYPH_WIDTH - lead - trail;
		for (int c = 0; c < ncols; c++) begin
			bits = entry[47 - 8 * (c + lead) -: 8];
			for (int r = 0; r < pgr_pkg::GLYPH_HEIGHT; r++) begin
				sum        = pen_col + c + r * stride_reg;
				pix.offset = sum[pgr_pkg::OFFSET_W-1:0];
				pix.value  = bits[r] ? fg_reg : bg_reg;
				pix.last   = (c == ncols - 1) && (r == pgr_pkg::GLYPH_HEIGHT - 1);
				pending_pixels.push_back(pix);
			end
		end
		// advance past the glyph and one spacing column, saturating
		sum     = pen_col + ncols + 1;
		pen_col = (sum > 16'hFFFF) ? 16'hFFFF : sum[pgr_pkg::CURSOR_W-1:0];
	endfunction

	// Pop pixels with random stalls and check each against the oldest prediction
	always @(posedge clk) begin : pixel_check
		pixel_t want;
		if (arst_n && pop && !empty) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel offset %0d", pixel_offset));
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_offset !== want.offset)
					report_mismatch($sformatf("pixel_offset %0d, want %0d",
						pixel_offset, want.offset));
				if (pixel_value !== want.value)
					report_mismatch($sformatf("pixel_value %0d, want %0d at offset %0d",
						pixel_value, want.value, want.offset));
				if (last_pixel !== want.last)
					report_mismatch($sformatf("last_pixel %0b, want %0b at offset %0d",
						last_pixel, want.last, want.offset));
			end
		end
		if (stall_left > 0) begin
			pop <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			pop <= 1'b1;
			if (idle_on && $urandom_range(0, 99) < 12)
				stall_left = pick_gap();
		end
	end

	// Offer one character and hold it until the block takes it
	task automatic send_char(input logic [pgr_pkg::CODE_W-1:0] code, input logic restart);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push       <= 1'b1;
		char_code  <= code;
		new_string <= restart;
		@(posedge clk);
		while (full) @(posedge clk);
		sent_chars++;
		render_glyph(code, restart);
	endtask

	// Drop push and wait until every predicted pixel is out and the block is quiet
	task automatic settle();
		push <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register with junk above its field, then read it back
	task automatic write_reg(input logic [pgr_pkg::REG_IDX_W-1:0] idx,
		input int unsigned value);
		logic [pgr_pkg::DATA_W-1:0] mask;
		logic [pgr_pkg::DATA_W-1:0] data;
		mask = (idx == pgr_pkg::REG_COLUMN_LIMIT) ? 32'h0000_FFFF : 32'h0000_00FF;
		data = ($urandom() & ~mask) | (value & mask);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			pgr_pkg::REG_ROW_STRIDE:   stride_reg = data[7:0];
			pgr_pkg::REG_FG_VALUE:     fg_reg     = data[pgr_pkg::PIX_W-1:0];
			pgr_pkg::REG_BG_VALUE:     bg_reg     = data[pgr_pkg::PIX_W-1:0];
			pgr_pkg::REG_COLUMN_LIMIT: limit_reg  = data[pgr_pkg::CURSOR_W-1:0];
			default:                   ;
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if ((prdata & mask) !== (data & mask))
			report_mismatch($sformatf("register %0d reads %0h, want %0h",
				idx, prdata & mask, data & mask));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Reset defaults: font edges, end of string and unprintable codes
	task automatic test_default_font();
		send_char(CH_SPACE, 1'b1);
		send_char(8'h21, 1'b0);      // narrowest glyph
		send_char(CH_HASH, 1'b0);    // five columns
		send_char(8'h40, 1'b0);      // bottom row bits set
		send_char(8'h51, 1'b0);
		send_char(8'h67, 1'b0);
		send_char(CH_TILDE, 1'b0);
		send_char(CH_END, 1'b0);
		send_char(8'h1f, 1'b0);
		send_char(8'h7f, 1'b0);
		send_char(8'h80, 1'b0);
		send_char(CH_LAST, 1'b0);
		send_char(CH_END, 1'b1);     // restarts the pen without drawing
		send_char(8'h41, 1'b0);
		settle();
	endtask

	// Stride, foreground, background and column limit at their extremes
	task automatic test_register_extremes();
		write_reg(pgr_pkg::REG_ROW_STRIDE, 0);
		write_reg(pgr_pkg::REG_FG_VALUE, 0);
		write_reg(pgr_pkg::REG_BG_VALUE, 255);
		write_reg(pgr_pkg::REG_COLUMN_LIMIT, 65535);
		send_char(8'h40, 1'b1);      // rows land on top of each other
		send_char(CH_HASH, 1'b0);
		settle();
		write_reg(pgr_pkg::REG_ROW_STRIDE, 255);
		write_reg(pgr_pkg::REG_FG_VALUE, 255);
		write_reg(pgr_pkg::REG_BG_VALUE, 0);
		send_char(8'h57, 1'b1);
		send_char(CH_TILDE, 1'b0);
		settle();
		write_reg(pgr_pkg::REG_ROW_STRIDE, 1);
		write_reg(pgr_pkg::REG_FG_VALUE, 'hA5);
		write_reg(pgr_pkg::REG_BG_VALUE, 'h5A);
		send_char(8'h79, 1'b1);
		send_char(8'h24, 1'b0);
		settle();
	endtask

	// Characters at or past the limit are dropped until a new string starts
	task automatic test_column_limit();
		write_reg(pgr_pkg::REG_COLUMN_LIMIT, 0);
		send_char(8'h41, 1'b1);
		settle();
		write_reg(pgr_pkg::REG_COLUMN_LIMIT, 9);
		send_char(8'h4d, 1'b1);
		send_char(8'h4d, 1'b0);
		send_char(8'h4d, 1'b0);
		send_char(8'h69, 1'b1);
		settle();
	endtask

	// Random strings under random register settings, with a little noise
	task automatic test_random_strings();
		int target, len;
		for (int phase = 0; phase < 5; phase++) begin
			case ($urandom_range(0, 3))
				0:       write_reg(pgr_pkg::REG_ROW_STRIDE, 0);
				1:       write_reg(pgr_pkg::REG_ROW_STRIDE, 255);
				default: write_reg(pgr_pkg::REG_ROW_STRIDE, $urandom_range(1, 254));
			endcase
			write_reg(pgr_pkg::REG_FG_VALUE, $urandom_range(0, 255));
			write_reg(pgr_pkg::REG_BG_VALUE, $urandom_range(0, 255));
			case ($urandom_range(0, 3))
				0:       write_reg(pgr_pkg::REG_COLUMN_LIMIT, $urandom_range(1, 20));
				1:       write_reg(pgr_pkg::REG_COLUMN_LIMIT, $urandom_range(20, 80));
				2:       write_reg(pgr_pkg::REG_COLUMN_LIMIT, 65535);
				default: write_reg(pgr_pkg::REG_COLUMN_LIMIT, $urandom_range(1, 65535));
			endcase
			// one phase runs back to back on both sides
			idle_on = (phase != 2);
			target  = sent_chars + PHASE_CHARS;
			while (sent_chars < target) begin
				if ($urandom_range(0, 9) < 8) begin
					len = $urandom_range(1, 12);
					send_char(rand_glyph(), 1'b1);
					for (int k = 1; k < len; k++)
						send_char(rand_glyph(), 1'b0);
					send_char(CH_END, 1'($urandom_range(0, 1)));
				end else begin
					send_char(pgr_pkg::CODE_W'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				end
			end
			settle();
			idle_on = 1'b1;
		end
	endtask

	initial begin : run
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_default_font();
		test_register_extremes();
		test_column_limit();
		test_random_strings();
		settle();
		if (mismatch_count == 0)
			$display("proportional_glyph_renderer_core regression: pass");
		else
			$display("proportional_glyph_renderer_core regression: fail");
		$finish;
	end

endmodule
